// ----- rtl/core/tsd_pkg.sv -----
`default_nettype none

package tsd_pkg;

  // Request function codes
  localparam logic [1:0] FUNC_TEXEL  = 2'd0;
  localparam logic [1:0] FUNC_CMAP   = 2'd1;
  localparam logic [1:0] FUNC_DRAW   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_WINDOW_X      = 2'd0;
  localparam logic [1:0] REG_WINDOW_Y      = 2'd1;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;
  localparam logic [1:0] REG_LOW_DETAIL    = 2'd3;

  localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd200;

  // Queue depths (powers of two)
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  // Classified request passed from front to back
  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] load_index;
    logic [15:0] load_value;
    logic [19:0] start_addr;
    logic [11:0] addr_step;
    logic        pair;
    logic [6:0]  count;
    logic [31:0] u_start;
    logic [31:0] v_start;
    logic [31:0] u_step;
    logic [31:0] v_step;
  } cmd_t;

  // One finished pixel
  typedef struct packed {
    logic [19:0] addr;
    logic [15:0] value;
    logic        pair;
    logic        last;
  } pix_t;

endpackage

`default_nettype wire

// ----- rtl/core/tsd_span_if.sv -----
`default_nettype none

interface tsd_span_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [11:0] load_index;
  logic [15:0] load_value;
  logic [9:0]  start_column;
  logic [9:0]  row;
  logic [5:0]  span_length;
  logic signed [31:0] u_start;
  logic signed [31:0] v_start;
  logic signed [31:0] u_step;
  logic signed [31:0] v_step;

  modport source (
    output valid, func, load_index, load_value, start_column, row, span_length,
           u_start, v_start, u_step, v_step,
    input  ready
  );
  modport sink (
    input  valid, func, load_index, load_value, start_column, row, span_length,
           u_start, v_start, u_step, v_step,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/tsd_pixel_if.sv -----
`default_nettype none

interface tsd_pixel_if;
  logic        valid;
  logic        ready;
  logic [19:0] pixel_address;
  logic [15:0] pixel_value;
  logic        pair_write;
  logic        last_pixel;

  modport source (
    output valid, pixel_address, pixel_value, pair_write, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_address, pixel_value, pair_write, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/tsd_cfg_if.sv -----
`default_nettype none

interface tsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [10:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tsd_queue.sv -----
`default_nettype none

module tsd_queue #(
  parameter int  DEPTH = 2,
  parameter type T     = logic
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push_valid,
  output logic                            push_ready,
  input  wire T                           push_data,
  output logic                            pop_valid,
  input  wire logic                       pop_ready,
  output T                                pop_data,
  output logic [$clog2(DEPTH):0]          count
);

  localparam int AW = $clog2(DEPTH);

  T              slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != (AW+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// ----- rtl/core/tsd_front.sv -----
`default_nettype none

module tsd_front
  import tsd_pkg::*;
#(
  parameter int MAX_SPAN = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  tsd_cfg_if.sink    cfg,
  tsd_span_if.sink   cmd,
  output logic       q_valid,
  input  wire logic  q_ready,
  output cmd_t       q_data
);

  // Configuration registers
  logic [9:0]  window_x;
  logic [9:0]  window_y;
  logic [10:0] screen_height;
  logic        low_detail;

  // Decode stage register
  logic        f_valid;
  cmd_t        f_cmd;
  logic [11:0] f_col_sum;
  logic [10:0] f_row_sum;
  logic [10:0] f_height;

  logic        take;
  logic [10:0] col;
  logic [6:0]  len_plus;
  logic [22:0] product;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_x      <= '0;
      window_y      <= '0;
      screen_height <= SCREEN_HEIGHT_RST;
      low_detail    <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_WINDOW_X:      window_x      <= cfg.wdata[9:0];
        REG_WINDOW_Y:      window_y      <= cfg.wdata[9:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg.wdata;
        REG_LOW_DETAIL:    low_detail    <= cfg.wdata[0];
        default: ;
      endcase
    end
  end

  // Accept when the stage is empty or moves on this cycle
  assign cmd.ready = !f_valid || q_ready;
  assign take      = cmd.valid && cmd.ready;

  assign col      = low_detail ? {cmd.start_column, 1'b0} : {1'b0, cmd.start_column};
  assign len_plus = {1'b0, cmd.span_length} + 7'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (cmd.ready) begin
      // unused function code is swallowed here
      f_valid <= cmd.valid && (cmd.func != FUNC_UNUSED);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_cmd.op         <= cmd.func;
      f_cmd.load_index <= cmd.load_index;
      f_cmd.load_value <= cmd.load_value;
      f_cmd.start_addr <= '0;
      f_cmd.addr_step  <= low_detail ? {screen_height, 1'b0} : {1'b0, screen_height};
      f_cmd.pair       <= low_detail;
      f_cmd.count      <= (len_plus > 7'(MAX_SPAN)) ? 7'(MAX_SPAN) : len_plus;
      f_cmd.u_start    <= cmd.u_start;
      f_cmd.v_start    <= cmd.v_start;
      f_cmd.u_step     <= cmd.u_step;
      f_cmd.v_step     <= cmd.v_step;
      f_col_sum        <= 12'(window_x) + 12'(col);
      f_row_sum        <= 11'(window_y) + 11'(cmd.row);
      f_height         <= screen_height;
    end
  end

  // Column-major start address, wrapped to 20 bits
  assign product = 23'(f_col_sum) * 23'(f_height);

  always_comb begin
    q_data            = f_cmd;
    q_data.start_addr = 20'(product + 23'(f_row_sum));
  end
  assign q_valid = f_valid;

endmodule

`default_nettype wire

// ----- rtl/core/tsd_back.sv -----
`default_nettype none

module tsd_back
  import tsd_pkg::*;
#(
  parameter int TILE_SHIFT = 6,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_valid,
  output logic                            q_ready,
  input  wire cmd_t                       q_data,
  output logic                            o_valid,
  output pix_t                            o_data,
  input  wire logic [$clog2(OUT_DEPTH):0] o_count
);

  localparam int IW   = 2 * TILE_SHIFT;
  localparam int LMW  = (PIXEL_BITS < 16) ? PIXEL_BITS : 16;
  localparam int OCW  = $clog2(OUT_DEPTH) + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } bstate_t;

  bstate_t state;
  bstate_t state_next;

  logic [7:0]     texture_tile [1 << IW];
  logic [LMW-1:0] light_map [256];

  // Span walker
  logic [31:0] u_accum;
  logic [31:0] v_accum;
  logic [31:0] u_step;
  logic [31:0] v_step;
  logic [19:0] next_address;
  logic [11:0] addr_step;
  logic        pair;
  logic [6:0]  pixels_left;

  // Lookup pipeline
  logic        s1_valid;
  pix_t        s1_pix;
  logic [7:0]  tex_q;
  logic        s2_valid;
  pix_t        s2_pix;
  logic [LMW-1:0] lm_q;

  logic          pop;
  logic          room;
  logic          issue;
  logic [IW-1:0] spot;
  logic [IW+11:0] load_ext;

  assign q_ready = (state == ST_IDLE);
  assign pop     = q_valid && q_ready;

  // Keep the output queue from overflowing with lookups in flight
  assign room  = (OCW'(s1_valid) + OCW'(s2_valid) + o_count) < OCW'(OUT_DEPTH);
  assign issue = (state == ST_RUN) && room;

  assign spot     = {v_accum[16 +: TILE_SHIFT], u_accum[16 +: TILE_SHIFT]};
  assign load_ext = {{IW{1'b0}}, q_data.load_index};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (pop && q_data.op == FUNC_DRAW) state_next = ST_RUN;
      ST_RUN:  if (issue && pixels_left == 7'd1) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Span state: loaded on a draw request, stepped per pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      u_accum      <= '0;
      v_accum      <= '0;
      next_address <= '0;
      pixels_left  <= '0;
    end else if (pop && q_data.op == FUNC_DRAW) begin
      u_accum      <= q_data.u_start;
      v_accum      <= q_data.v_start;
      next_address <= q_data.start_addr;
      pixels_left  <= q_data.count;
    end else if (issue) begin
      u_accum      <= u_accum + u_step;
      v_accum      <= v_accum + v_step;
      next_address <= next_address + 20'(addr_step);
      pixels_left  <= pixels_left - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_data.op == FUNC_DRAW) begin
      u_step    <= q_data.u_step;
      v_step    <= q_data.v_step;
      addr_step <= q_data.addr_step;
      pair      <= q_data.pair;
    end
  end

  // Texture tile: loads write, walker reads
  always_ff @(posedge clk) begin
    if (pop && q_data.op == FUNC_TEXEL) begin
      texture_tile[load_ext[IW-1:0]] <= q_data.load_value[7:0];
    end
    tex_q <= texture_tile[spot];
  end

  // Light map: read with the texel from the previous cycle
  always_ff @(posedge clk) begin
    if (pop && q_data.op == FUNC_CMAP) begin
      light_map[q_data.load_index[7:0]] <= q_data.load_value[LMW-1:0];
    end
    lm_q <= light_map[tex_q];
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix.addr  <= next_address;
    s1_pix.value <= '0;
    s1_pix.pair  <= pair;
    s1_pix.last  <= (pixels_left == 7'd1);
    s2_pix       <= s1_pix;
  end

  always_comb begin
    o_data       = s2_pix;
    o_data.value = 16'(lm_q);
  end
  assign o_valid = s2_valid;

endmodule

`default_nettype wire

// ----- rtl/core/textured_span_draw.sv -----
`default_nettype none

// Affine texture span mapper. Requests on cmd either load one texel of the
// square tile (side 1 << TILE_SHIFT), load one light map entry, or draw a
// span; each span pixel comes out on pix with its column-major framebuffer
// address. The back end takes a load and stays idle; it walks a span one
// pixel per cycle while the pixel queue has room, in the single span walker
// with its texel and light map lookups (two memory read stages). Decode and
// the start-address multiply share one register stage ahead of a two-entry
// request queue, and a four-entry pixel queue absorbs output stalls. The
// front end keeps taking requests during a span until the queue is full.
// Write configuration only while the block is idle.
module textured_span_draw
  import tsd_pkg::*;
#(
  parameter int TILE_SHIFT = 6,
  parameter int PIXEL_BITS = 16,
  parameter int MAX_SPAN   = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  tsd_cfg_if.sink    cfg,
  tsd_span_if.sink   cmd,
  tsd_pixel_if.source pix
);

  localparam int OCW = $clog2(OUT_DEPTH) + 1;

  logic           fq_valid;
  logic           fq_ready;
  cmd_t           fq_data;
  logic           bq_valid;
  logic           bq_ready;
  cmd_t           bq_data;
  logic           po_valid;
  pix_t           po_data;
  pix_t           out_data;
  logic [OCW-1:0] out_count;

  tsd_front #(
    .MAX_SPAN (MAX_SPAN)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_data  (fq_data)
  );

  tsd_queue #(
    .DEPTH (CMD_DEPTH),
    .T     (cmd_t)
  ) u_cmd_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_data   (bq_data),
    .count      ()
  );

  tsd_back #(
    .TILE_SHIFT (TILE_SHIFT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (bq_valid),
    .q_ready (bq_ready),
    .q_data  (bq_data),
    .o_valid (po_valid),
    .o_data  (po_data),
    .o_count (out_count)
  );

  tsd_queue #(
    .DEPTH (OUT_DEPTH),
    .T     (pix_t)
  ) u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (po_valid),
    .push_ready (),
    .push_data  (po_data),
    .pop_valid  (pix.valid),
    .pop_ready  (pix.ready),
    .pop_data   (out_data),
    .count      (out_count)
  );

  assign pix.pixel_address = out_data.addr;
  assign pix.pixel_value   = out_data.value;
  assign pix.pair_write    = out_data.pair;
  assign pix.last_pixel    = out_data.last;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import tsd_pkg::*;

  localparam int SETTLE_CYCLES = 32;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 6;

  // Spans only ever read this tile row; texel loads mostly pick these light map entries
  localparam logic [5:0] TEX_ROW   = 6'd42;
  localparam int         SHADES    = 8;
  localparam int         SHADE_GAP = 36;

  // One request as offered on the span channel
  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] load_index;
    logic [15:0] load_value;
    logic [9:0]  start_column;
    logic [9:0]  row;
    logic [5:0]  span_length;
    logic [31:0] u_start;
    logic [31:0] v_start;
    logic [31:0] u_step;
    logic [31:0] v_step;
  } span_req_t;

  // Tracks tile, light map and registers; queues the pixels each span should give
  class pixel_ledger;
    bit [7:0]  tile [4096];
    bit [15:0] shade [256];
    bit [9:0]  win_x;
    bit [9:0]  win_y;
    bit [10:0] scr_h;
    bit        low_det;
    pix_t      pending_pixels [$];
    int        failures;
    int        pixels_seen;

    function new();
      win_x       = '0;
      win_y       = '0;
      scr_h       = SCREEN_HEIGHT_RST;
      low_det     = 1'b0;
      failures    = 0;
      pixels_seen = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [10:0] val);
      case (idx)
        REG_WINDOW_X:      win_x   = val[9:0];
        REG_WINDOW_Y:      win_y   = val[9:0];
        REG_SCREEN_HEIGHT: scr_h   = val;
        REG_LOW_DETAIL:    low_det = val[0];
        default: ;
      endcase
    endfunction

    // Note an accepted request: loads update the stores, a span walks u/v
    function void take_request(span_req_t r);
      bit [31:0] addr;
      bit [31:0] stride;
      bit [31:0] col;
      bit [31:0] u;
      bit [31:0] v;
      bit [11:0] spot;
      int        n;
      pix_t      px;
      case (r.func)
        FUNC_TEXEL: tile[r.load_index] = r.load_value[7:0];
        FUNC_CMAP:  shade[r.load_index[7:0]] = r.load_value;
        FUNC_DRAW: begin
          n      = int'(r.span_length) + 1;
          col    = low_det ? {r.start_column, 1'b0} : r.start_column;
          stride = low_det ? {scr_h, 1'b0} : scr_h;
          addr   = (win_x + col) * scr_h + win_y + r.row;
          u      = r.u_start;
          v      = r.v_start;
          for (int k = 0; k < n; k++) begin
            // row from v integer part, column from u integer part
            spot     = {v[21:16], u[21:16]};
            px.addr  = addr[19:0];
            px.value = shade[tile[spot]];
            px.pair  = low_det;
            px.last  = (k == n - 1);
            pending_pixels.push_back(px);
            addr += stride;
            u    += r.u_step;
            v    += r.v_step;
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      failures++;
      if (failures <= 40)
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compare a delivered pixel with the oldest one still owed
    task match_pixel(pix_t got);
      pix_t want;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel addr %05h value %04h",
                                  got.addr, got.value));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.addr !== want.addr)
        report_mismatch($sformatf("pixel %0d address %05h, want %05h",
                                  pixels_seen, got.addr, want.addr));
      if (got.value !== want.value)
        report_mismatch($sformatf("pixel %0d value %04h, want %04h",
                                  pixels_seen, got.value, want.value));
      if (got.pair !== want.pair)
        report_mismatch($sformatf("pixel %0d pair flag %b, want %b",
                                  pixels_seen, got.pair, want.pair));
      if (got.last !== want.last)
        report_mismatch($sformatf("pixel %0d last flag %b, want %b",
                                  pixels_seen, got.last, want.last));
      pixels_seen++;
    endtask
  endclass

  logic clk;
  logic rst;

  tsd_cfg_if   cfg_ch();
  tsd_span_if  span_ch();
  tsd_pixel_if pixel_ch();

  pixel_ledger ledger;
  bit calm;         // no idling on either side
  bit hold_pixels;  // ask the pixel side for one long hold-off
  int spans_sent;
  int loads_sent;
  int settings_used;

  textured_span_draw dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .cmd (span_ch),
    .pix (pixel_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop
  initial begin
    #10_000_000;
    $display("Run timed out with %0d pixels still owed", ledger.pending_pixels.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Pixel side: random stall bursts, plus one long hold-off on request
  initial begin : pixel_sink
    int stall_left;
    int hold_left;
    stall_left     = 0;
    hold_left      = 0;
    pixel_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pixels) begin
        hold_pixels = 1'b0;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pixel_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pixel_ch.ready = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left     = $urandom_range(1, 6) - 1;
        pixel_ch.ready = 1'b0;
      end else begin
        pixel_ch.ready = 1'b1;
      end
    end
  end

  // Check every accepted pixel
  always @(posedge clk) begin
    if (!rst && pixel_ch.valid && pixel_ch.ready)
      ledger.match_pixel(pix_t'({pixel_ch.pixel_address, pixel_ch.pixel_value,
                                 pixel_ch.pair_write, pixel_ch.last_pixel}));
  end

  // A texel byte whose light map entry is always loaded
  function automatic logic [7:0] shade_pick();
    return 8'($urandom_range(0, SHADES - 1) * SHADE_GAP);
  endfunction

  function automatic span_req_t load(logic [1:0] func, logic [11:0] idx,
                                     logic [15:0] val);
    span_req_t r;
    r            = '0;
    r.func       = func;
    r.load_index = idx;
    r.load_value = val;
    return r;
  endfunction

  // v is pinned to the filled tile row; its step moves only the bits above it
  function automatic span_req_t draw(logic [9:0] col, logic [9:0] row, logic [5:0] len,
                                     logic [31:0] us, logic [31:0] vs,
                                     logic [31:0] ud, logic [31:0] vd);
    span_req_t r;
    r              = load(FUNC_DRAW, 12'($urandom()), 16'($urandom()));
    r.start_column = col;
    r.row          = row;
    r.span_length  = len;
    r.u_start      = us;
    r.v_start      = {vs[31:22], TEX_ROW, vs[15:0]};
    r.u_step       = ud;
    r.v_step       = {vd[31:22], 22'd0};
    return r;
  endfunction

  // Mostly spans, some loads, the odd unused func; half the spans step u gently
  function automatic span_req_t random_request();
    span_req_t r;
    int pick;
    r = draw(10'($urandom()), 10'($urandom()), 6'($urandom()), $urandom(), $urandom(),
             $urandom(), $urandom());
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      r.func       = FUNC_TEXEL;
      r.load_index = ($urandom_range(0, 1) == 1) ? {TEX_ROW, 6'($urandom())}
                                                 : 12'($urandom());
      r.load_value = {8'($urandom()), shade_pick()};
    end else if (pick < 35) begin
      r.func       = FUNC_CMAP;
      r.load_index = {4'($urandom()), shade_pick()};
    end else if (pick >= 97) begin
      r.func = FUNC_UNUSED;
    end
    if (r.func == FUNC_DRAW && $urandom_range(0, 1) == 1)
      r.u_step = 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
    return r;
  endfunction

  task automatic idle_requests(int cycles);
    @(negedge clk);
    span_ch.valid   = 1'b0;
    span_ch.u_start = $urandom();
    span_ch.v_step  = $urandom();
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Offer one request, maybe after an idle burst, and wait for it to be taken
  task automatic offer(span_req_t r);
    if (!calm && $urandom_range(0, 3) == 0)
      idle_requests($urandom_range(1, 6));
    @(negedge clk);
    span_ch.valid        = 1'b1;
    span_ch.func         = r.func;
    span_ch.load_index   = r.load_index;
    span_ch.load_value   = r.load_value;
    span_ch.start_column = r.start_column;
    span_ch.row          = r.row;
    span_ch.span_length  = r.span_length;
    span_ch.u_start      = r.u_start;
    span_ch.v_start      = r.v_start;
    span_ch.u_step       = r.u_step;
    span_ch.v_step       = r.v_step;
    do @(posedge clk); while (!span_ch.ready);
    ledger.take_request(r);
    if (r.func == FUNC_DRAW)
      spans_sent++;
    else if (r.func != FUNC_UNUSED)
      loads_sent++;
  endtask

  task automatic write_registers(logic [9:0] wx, logic [9:0] wy, logic [10:0] sh,
                                 logic ld);
    logic [10:0] vals [4];
    vals[REG_WINDOW_X]      = 11'(wx);
    vals[REG_WINDOW_Y]      = 11'(wy);
    vals[REG_SCREEN_HEIGHT] = sh;
    vals[REG_LOW_DETAIL]    = 11'(ld);
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_ch.valid = 1'b1;
      cfg_ch.addr  = 2'(i);
      cfg_ch.wdata = vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
      ledger.set_register(2'(i), vals[i]);
    end
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    settings_used++;
  endtask

  // Let all owed pixels arrive, then give trailing loads time to retire
  task automatic wait_for_pixels(int limit);
    int waited;
    waited = 0;
    @(negedge clk);
    span_ch.valid = 1'b0;
    while (ledger.pending_pixels.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    if (ledger.pending_pixels.size() != 0) begin
      ledger.report_mismatch($sformatf("%0d expected pixels never arrived",
                                       ledger.pending_pixels.size()));
      ledger.pending_pixels.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    span_req_t r;
    int counted;
    ledger        = new();
    rst           = 1'b1;
    calm          = 1'b0;
    hold_pixels   = 1'b0;
    spans_sent    = 0;
    loads_sent    = 0;
    settings_used = 1;
    cfg_ch.valid  = 1'b0;
    cfg_ch.addr   = REG_WINDOW_X;
    cfg_ch.wdata  = '0;
    span_ch.valid = 1'b0;
    span_ch.func  = FUNC_TEXEL;
    span_ch.load_index   = '0;
    span_ch.load_value   = '0;
    span_ch.start_column = '0;
    span_ch.row          = '0;
    span_ch.span_length  = '0;
    span_ch.u_start      = '0;
    span_ch.v_start      = '0;
    span_ch.u_step       = '0;
    span_ch.v_step       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill the texture row and the light entries that spans can reach
    for (int i = 0; i < 64; i++)
      offer(load(FUNC_TEXEL, {TEX_ROW, 6'(i)}, {8'($urandom()), shade_pick()}));
    for (int i = 0; i < SHADES; i++)
      offer(load(FUNC_CMAP, 12'(i * SHADE_GAP), 16'($urandom())));

    // Directed part, under the reset register values
    offer(load(FUNC_TEXEL, {TEX_ROW, 6'd63}, 16'hFFFF));   // only low byte kept
    offer(load(FUNC_TEXEL, {TEX_ROW, 6'd0}, 16'hFF00));
    offer(load(FUNC_CMAP, 12'hFFF, 16'hFFFF));    // index folds to 255
    offer(load(FUNC_CMAP, 12'h100, 16'h0000));    // index folds to 0
    offer(draw(10'd0, 10'd0, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0));
    // coordinates wrap past the top of the signed range
    offer(draw(10'd1023, 10'd1023, 6'd63, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF));
    offer(draw(10'd512, 10'd200, 6'd63, 32'h8000_0000, 32'h8000_0000,
               32'hFFFF_FFFF, 32'hFFFF_FFFF));
    offer(draw(10'd1, 10'd1, 6'd0, 32'h003F_0000, 32'h003F_0000, 32'h0, 32'h0));
    // walking backwards through the tile
    offer(draw(10'd100, 10'd50, 6'd31, 32'h0020_0000, 32'h0020_0000,
               32'hFFFF_0000, 32'hFFFF_0000));
    r      = random_request();
    r.func = FUNC_UNUSED;
    offer(r);
    offer(draw(10'd3, 10'd4, 6'd5, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_8000,
               32'h0001_8000));
    offer(draw(10'd0, 10'd199, 6'd63, 32'h0, 32'h0011_0000, 32'h0001_0000, 32'h0));
    offer(draw(10'd7, 10'd0, 6'd63, 32'h0005_0000, 32'h0, 32'h0, 32'h0001_0000));
    // a fresh texel and light entry seen straight after loading
    offer(load(FUNC_TEXEL, {TEX_ROW, 6'd7}, 16'h00A5));
    offer(load(FUNC_CMAP, 12'h0A5, 16'h5A5A));
    offer(draw(10'd10, 10'd10, 6'd0, 32'h0007_0000, 32'h0005_0000, 32'h0, 32'h0));
    // fraction carries into the integer part
    offer(draw(10'd1023, 10'd0, 6'd63, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
               32'h8000_0001));
    wait_for_pixels(DRAIN_LIMIT);

    // Random part over several register settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       write_registers(10'd1023, 10'd1023, 11'd2047, 1'b1);
        1:       write_registers(10'd0, 10'd0, 11'd0, 1'b0);
        2:       write_registers(10'd517, 10'd33, 11'd1, 1'b1);
        3:       write_registers(10'd1023, 10'd0, 11'd1024, 1'b0);
        4:       write_registers(10'd0, 10'd1023, 11'd320, 1'b1);
        default: write_registers(10'($urandom()), 10'($urandom()),
                                 11'($urandom_range(1, 2047)), 1'b0);
      endcase
      hold_pixels = (p == 2);
      calm        = (p == 5);
      counted     = 0;
      while (counted < PHASE_ITEMS) begin
        r = random_request();
        // a full-length span first, so the long hold-off backs up the input
        if (p == 2 && counted == 0) begin
          r.func        = FUNC_DRAW;
          r.span_length = 6'd63;
        end
        offer(r);
        if (r.func != FUNC_UNUSED)
          counted++;
      end
      wait_for_pixels(DRAIN_LIMIT);
    end

    $display("Checked %0d pixels from %0d spans, with %0d tile and light map loads",
             ledger.pixels_seen, spans_sent, loads_sent);
    $display("over %0d register settings, low detail and zero/full screen height included",
             settings_used);
    if (ledger.failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
